/* hdl/ccr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg
// Widths, constants and types of the Compton cone reconstruction pipeline.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int EW = 20;
  localparam int PW = 24;
  localparam int MW = PW + 1;

  localparam int MEW = 30;
  localparam logic [MEW-1:0] ME_Q16 = 30'd535821183;
  localparam int NUMW = MEW + EW;
  localparam int ESW = EW + 1;
  localparam int DENW = EW + ESW;
  localparam int CQB = 18;
  localparam int CCW = DENW + CQB;

  localparam int NB = 30;
  localparam int NORM_TOP = NB - 1;
  localparam int SHW = $clog2(NB);
  localparam int SUMW = 2 * NB + 2;
  localparam int SQB = SUMW / 2;
  localparam int SRW = SQB + 2;

  localparam int AQB = 16;
  localparam int AFRAC = AQB - 1;
  localparam int ANW = NB + AFRAC + 1;
  localparam int ACW = SQB + AQB;

  localparam int CW = 16;
  localparam int COS_ONE = 16384;
  localparam int COS_LIM = 2 * COS_ONE;
  localparam int AXIS_MAX = 32767;

  typedef logic [EW-1:0] energy_t;
  typedef logic signed [PW-1:0] pos_t;
  typedef logic [2:0][NB-1:0] nmag_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
  } axflag_t;

endpackage

/* hdl/compton_cone_reconstruct_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compton_cone_reconstruct_unit
// Two-hit Compton cone kinematics: scatter cosine, cone vertex and unit axis.
//
//   Channel  Ports                 Handshake
//   input    in_*                  word taken when start is high and busy low
//   result   out_*                 one word per out_valid cycle, no back-pressure
//
// A new word can be taken in every cycle; busy is always low.
// The result word is registered on out_*; its delay is set
// mostly by the 31-step square root followed by the 16-step axis division.
// Reset clears only the valid bits; data registers are not reset.
// The pipeline never stalls, since the receiver cannot hold results off.
// ----------------------------------------------------------------------------
module compton_cone_reconstruct_unit
  import ccr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [EW-1:0]        in_energy_first,
  input  logic [EW-1:0]        in_energy_second,
  input  logic signed [PW-1:0] in_first_x,
  input  logic signed [PW-1:0] in_first_y,
  input  logic signed [PW-1:0] in_first_z,
  input  logic signed [PW-1:0] in_second_x,
  input  logic signed [PW-1:0] in_second_y,
  input  logic signed [PW-1:0] in_second_z,
  input  logic                 in_swap_order,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_cos_scatter,
  output logic signed [PW-1:0] out_vertex_x,
  output logic signed [PW-1:0] out_vertex_y,
  output logic signed [PW-1:0] out_vertex_z,
  output logic signed [CW-1:0] out_axis_x,
  output logic signed [CW-1:0] out_axis_y,
  output logic signed [CW-1:0] out_axis_z,
  output logic                 out_invalid
);

  localparam int LAST = 5 + SQB + 1 + AQB;
  localparam int CDL = LAST - (3 + CQB);
  localparam int VDL = LAST;
  localparam int SR_CHK = 5 + SQB - 1;

  logic acc;

  energy_t              s1_e1_nxt, s1_e2_nxt, s1_e1_r, s1_e2_r;
  logic [ESW-1:0]       s1_es_nxt, s1_es_r;
  pos_t                 p1 [3];
  pos_t                 p2 [3];
  logic signed [MW-1:0] dd [3];
  logic [MW-1:0]        s1_mag_nxt [3];
  logic [MW-1:0]        s1_mag_r [3];
  logic [2:0]           s1_sgn_nxt, s1_sgn_r;

  logic [NUMW-1:0] s2_num_nxt, s2_num_r;
  logic [DENW-1:0] s2_den_nxt, s2_den_r;
  logic [MW-1:0]   s2_max_nxt, s2_max_r, m01;
  logic [MW-1:0]   s2_mag_r [3];
  logic [2:0]      s2_sgn_r;

  logic [NUMW-1:0] c_rem_nxt [0:CQB];
  logic [NUMW-1:0] c_rem_r   [0:CQB];
  logic [DENW-1:0] c_den_nxt [0:CQB];
  logic [DENW-1:0] c_den_r   [0:CQB];
  logic [CQB-1:0]  c_q_nxt   [0:CQB];
  logic [CQB-1:0]  c_q_r     [0:CQB];
  logic            c_ovf_nxt [0:CQB];
  logic            c_ovf_r   [0:CQB];

  logic [CQB:0]    tsum;
  logic [CQB-2:0]  tval;
  logic [CQB-1:0]  cosw;
  logic            cf_bad_nxt;
  logic [CW-1:0]   cf_cos_nxt;
  logic [CW:0]     cd_r [0:CDL-1];

  logic [SHW-1:0]  msb_pos, shamt;
  nmag_t           a3_nm_nxt, a3_nm_r;
  axflag_t         a3_fl_nxt, a3_fl_r;
  logic [2*NB-1:0] a4_sq_nxt [3];
  logic [2*NB-1:0] a4_sq_r [3];
  nmag_t           a4_nm_r;
  axflag_t         a4_fl_r;

  logic [SUMW-1:0] sr_src_nxt  [0:SQB];
  logic [SUMW-1:0] sr_src_r    [0:SQB];
  logic [SRW-1:0]  sr_rem_nxt  [0:SQB];
  logic [SRW-1:0]  sr_rem_r    [0:SQB];
  logic [SQB-1:0]  sr_root_nxt [0:SQB];
  logic [SQB-1:0]  sr_root_r   [0:SQB];
  nmag_t           sr_nm_r     [0:SQB];
  axflag_t         sr_fl_r     [0:SQB];

  logic [2:0][ANW-1:0] dv_rem_nxt [0:AQB];
  logic [2:0][ANW-1:0] dv_rem_r   [0:AQB];
  logic [2:0][AQB-1:0] dv_q_nxt   [0:AQB];
  logic [2:0][AQB-1:0] dv_q_r     [0:AQB];
  logic [SQB-1:0]      dv_n_r     [0:AQB];
  axflag_t             dv_fl_r    [0:AQB];

  logic [2:0][CW-1:0] ax_nxt;
  logic [AQB-1:0]     qc;

  logic [3*PW-1:0] vd_r [0:VDL-1];
  logic [LAST-1:0] vld_r;
  logic            out_valid_r, out_invalid_r;
  logic [CW-1:0]   out_cos_r;
  logic [3*PW-1:0] out_vtx_r;
  logic [2:0][CW-1:0] out_axis_r;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_comb begin
    s1_e1_nxt = in_swap_order ? in_energy_second : in_energy_first;
    s1_e2_nxt = in_swap_order ? in_energy_first : in_energy_second;
    s1_es_nxt = ESW'(s1_e1_nxt) + ESW'(s1_e2_nxt);
    p1[0] = in_swap_order ? in_second_x : in_first_x;
    p1[1] = in_swap_order ? in_second_y : in_first_y;
    p1[2] = in_swap_order ? in_second_z : in_first_z;
    p2[0] = in_swap_order ? in_first_x : in_second_x;
    p2[1] = in_swap_order ? in_first_y : in_second_y;
    p2[2] = in_swap_order ? in_first_z : in_second_z;
    for (int i = 0; i < 3; i++) begin
      dd[i] = MW'(p1[i]) - MW'(p2[i]);
      s1_sgn_nxt[i] = dd[i][MW-1];
      s1_mag_nxt[i] = s1_sgn_nxt[i] ? MW'(-dd[i]) : MW'(dd[i]);
    end
  end

  always_comb begin
    s2_num_nxt = NUMW'(ME_Q16) * NUMW'(s1_e1_r);
    s2_den_nxt = DENW'(s1_e2_r) * DENW'(s1_es_r);
    m01 = (s1_mag_r[0] > s1_mag_r[1]) ? s1_mag_r[0] : s1_mag_r[1];
    s2_max_nxt = (m01 > s1_mag_r[2]) ? m01 : s1_mag_r[2];
  end

  always_comb begin
    c_rem_nxt[0] = s2_num_r;
    c_den_nxt[0] = s2_den_r;
    c_q_nxt[0]   = '0;
    c_ovf_nxt[0] = CCW'(s2_num_r) >= (CCW'(s2_den_r) << CQB);
    for (int k = 1; k <= CQB; k++) begin
      c_den_nxt[k] = c_den_r[k-1];
      c_ovf_nxt[k] = c_ovf_r[k-1];
      if (CCW'(c_rem_r[k-1]) >= (CCW'(c_den_r[k-1]) << (CQB - k))) begin
        c_rem_nxt[k] = NUMW'(CCW'(c_rem_r[k-1]) - (CCW'(c_den_r[k-1]) << (CQB - k)));
        c_q_nxt[k]   = {c_q_r[k-1][CQB-2:0], 1'b1};
      end else begin
        c_rem_nxt[k] = c_rem_r[k-1];
        c_q_nxt[k]   = {c_q_r[k-1][CQB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    tsum = (CQB+1)'(c_q_r[CQB]) + (CQB+1)'(2);
    tval = tsum[CQB:2];
    cf_bad_nxt = c_ovf_r[CQB] || (tval > (CQB-1)'(COS_LIM));
    cosw = CQB'(COS_ONE) - CQB'(tval);
    cf_cos_nxt = cf_bad_nxt ? CW'(-COS_ONE) : cosw[CW-1:0];
  end

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < MW; i++) begin
      if (s2_max_r[i]) begin
        msb_pos = SHW'(i);
      end
    end
    shamt = SHW'(NORM_TOP) - msb_pos;
    for (int i = 0; i < 3; i++) begin
      a3_nm_nxt[i] = NB'(s2_mag_r[i]) << shamt;
    end
    a3_fl_nxt.sgn  = s2_sgn_r;
    a3_fl_nxt.zero = (s2_max_r == '0);
    for (int i = 0; i < 3; i++) begin
      a4_sq_nxt[i] = (2*NB)'(a3_nm_r[i]) * (2*NB)'(a3_nm_r[i]);
    end
  end

  always_comb begin
    sr_src_nxt[0]  = SUMW'(a4_sq_r[0]) + SUMW'(a4_sq_r[1]) + SUMW'(a4_sq_r[2]);
    sr_rem_nxt[0]  = '0;
    sr_root_nxt[0] = '0;
    for (int k = 1; k <= SQB; k++) begin
      sr_src_nxt[k] = sr_src_r[k-1] << 2;
      if ({sr_rem_r[k-1], sr_src_r[k-1][SUMW-1 -: 2]} >=
          (SRW+2)'({sr_root_r[k-1], 2'b01})) begin
        sr_rem_nxt[k]  = SRW'({sr_rem_r[k-1], sr_src_r[k-1][SUMW-1 -: 2]} -
                              (SRW+2)'({sr_root_r[k-1], 2'b01}));
        sr_root_nxt[k] = {sr_root_r[k-1][SQB-2:0], 1'b1};
      end else begin
        sr_rem_nxt[k]  = SRW'({sr_rem_r[k-1], sr_src_r[k-1][SUMW-1 -: 2]});
        sr_root_nxt[k] = {sr_root_r[k-1][SQB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_nxt[0][i] = (ANW'(sr_nm_r[SQB][i]) << AFRAC) + ANW'(sr_root_r[SQB] >> 1);
      dv_q_nxt[0][i]   = '0;
    end
    for (int k = 1; k <= AQB; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (ACW'(dv_rem_r[k-1][i]) >= (ACW'(dv_n_r[k-1]) << (AQB - k))) begin
          dv_rem_nxt[k][i] = ANW'(ACW'(dv_rem_r[k-1][i]) -
                                  (ACW'(dv_n_r[k-1]) << (AQB - k)));
          dv_q_nxt[k][i]   = {dv_q_r[k-1][i][AQB-2:0], 1'b1};
        end else begin
          dv_rem_nxt[k][i] = dv_rem_r[k-1][i];
          dv_q_nxt[k][i]   = {dv_q_r[k-1][i][AQB-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    qc = '0;
    for (int i = 0; i < 3; i++) begin
      qc = (dv_q_r[AQB][i] > AQB'(AXIS_MAX)) ? AQB'(AXIS_MAX) : dv_q_r[AQB][i];
      if (dv_fl_r[AQB].zero) begin
        ax_nxt[i] = '0;
      end else if (dv_fl_r[AQB].sgn[i]) begin
        ax_nxt[i] = CW'(-qc);
      end else begin
        ax_nxt[i] = CW'(qc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[LAST-2:0], acc};
      out_valid_r <= vld_r[LAST-1];
    end
  end

  always_ff @(posedge clk) begin
    s1_e1_r  <= s1_e1_nxt;
    s1_e2_r  <= s1_e2_nxt;
    s1_es_r  <= s1_es_nxt;
    s1_sgn_r <= s1_sgn_nxt;
    s1_mag_r <= s1_mag_nxt;
    s2_num_r <= s2_num_nxt;
    s2_den_r <= s2_den_nxt;
    s2_max_r <= s2_max_nxt;
    s2_mag_r <= s1_mag_r;
    s2_sgn_r <= s1_sgn_r;
    for (int k = 0; k <= CQB; k++) begin
      c_rem_r[k] <= c_rem_nxt[k];
      c_den_r[k] <= c_den_nxt[k];
      c_q_r[k]   <= c_q_nxt[k];
      c_ovf_r[k] <= c_ovf_nxt[k];
    end
    cd_r[0] <= {cf_bad_nxt, cf_cos_nxt};
    for (int j = 1; j < CDL; j++) begin
      cd_r[j] <= cd_r[j-1];
    end
    vd_r[0] <= {p1[0], p1[1], p1[2]};
    for (int j = 1; j < VDL; j++) begin
      vd_r[j] <= vd_r[j-1];
    end
    a3_nm_r <= a3_nm_nxt;
    a3_fl_r <= a3_fl_nxt;
    a4_sq_r <= a4_sq_nxt;
    a4_nm_r <= a3_nm_r;
    a4_fl_r <= a3_fl_r;
    for (int k = 0; k <= SQB; k++) begin
      sr_src_r[k]  <= sr_src_nxt[k];
      sr_rem_r[k]  <= sr_rem_nxt[k];
      sr_root_r[k] <= sr_root_nxt[k];
    end
    sr_nm_r[0] <= a4_nm_r;
    sr_fl_r[0] <= a4_fl_r;
    for (int k = 1; k <= SQB; k++) begin
      sr_nm_r[k] <= sr_nm_r[k-1];
      sr_fl_r[k] <= sr_fl_r[k-1];
    end
    for (int k = 0; k <= AQB; k++) begin
      dv_rem_r[k] <= dv_rem_nxt[k];
      dv_q_r[k]   <= dv_q_nxt[k];
    end
    dv_n_r[0]  <= sr_root_r[SQB];
    dv_fl_r[0] <= sr_fl_r[SQB];
    for (int k = 1; k <= AQB; k++) begin
      dv_n_r[k]  <= dv_n_r[k-1];
      dv_fl_r[k] <= dv_fl_r[k-1];
    end
    out_cos_r     <= cd_r[CDL-1][CW-1:0];
    out_invalid_r <= cd_r[CDL-1][CW];
    out_vtx_r     <= vd_r[VDL-1];
    out_axis_r    <= ax_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cos_scatter = out_cos_r;
  assign out_invalid     = out_invalid_r;
  assign out_vertex_x    = out_vtx_r[3*PW-1 -: PW];
  assign out_vertex_y    = out_vtx_r[2*PW-1 -: PW];
  assign out_vertex_z    = out_vtx_r[PW-1:0];
  assign out_axis_x      = out_axis_r[0];
  assign out_axis_y      = out_axis_r[1];
  assign out_axis_z      = out_axis_r[2];

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAST + 1))
    else $error("result word without an accepted input word");

  a_cos_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cos_scatter >= -16'sd16384) && (out_cos_scatter <= 16'sd16384))
    else $error("scatter cosine out of range");

  a_invalid_cos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_cos_scatter == -16'sd16384))
    else $error("invalid word without saturated cosine");

  a_root_norm : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[SR_CHK] && !sr_fl_r[SQB].zero) |->
      (sr_root_r[SQB][SQB-1] || sr_root_r[SQB][SQB-2]))
    else $error("axis norm not normalized");

endmodule
